### rtl/baled_pkg.sv
// Shared constants and types for the bit angle LED driver.
package baled_pkg;

  localparam int LED_NUM    = 6;
  localparam int LEVEL_BITS = 8;

  localparam int HOLD_W  = LEVEL_BITS - 1;
  localparam int SLICE_W = (LEVEL_BITS > 1) ? $clog2(LEVEL_BITS) : 1;

  // stream field widths fixed by the item format
  localparam int KIND_W   = 2;
  localparam int MASK_W   = 6;
  localparam int VALUE_W  = 8;
  localparam int PINS_W   = 6;
  localparam int PERIOD_W = 16;

  localparam int IN_DATA_W  = 16;  // led_mask + level_value, byte padded
  localparam int OUT_DATA_W = 8;   // led_pins, byte padded

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'h00ff;

  typedef enum logic [KIND_W-1:0] {
    KIND_MOD_TICK  = 2'd0,
    KIND_PASS_TICK = 2'd1,
    KIND_SET_SOLID = 2'd2,
    KIND_START_PULSE = 2'd3
  } kind_t;

  typedef logic [LEVEL_BITS-1:0] level_t;

endpackage

### rtl/bit_angle_led_driver_with_pulse.sv
// Top level: binary code modulation driver for the LEDs, with pulse ramps.
//
//   channel   | direction | signals                          | contents
//   ----------+-----------+----------------------------------+---------------------------------
//   s_axis    | in        | tvalid, tready, tdata, tuser     | tick or command item
//   m_axis    | out       | tvalid, tready, tdata            | pin state after each item
//   cfg       | in        | cfg_wr_en, cfg_wr_data           | update_period register
//
// One item per cycle while tready is high: the item and the LED state feed short logic whose
// result is written to the state registers and to the output register (or to the skid entry
// while the output register is full and not read) at the edge that accepts the item.
// A two-entry output queue (output register plus skid) keeps input ready
// while one result waits; tready falls only when both entries are full.
// Reset (rst, synchronous) clears all levels, modes, counters, the pins and
// the queue, and loads update_period with 255.
module bit_angle_led_driver_with_pulse
  import baled_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // configuration
  input  logic                  cfg_wr_en,
  input  logic [PERIOD_W-1:0]   cfg_wr_data,
  // input items
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [5:0] led_mask, [13:6] level_value
  input  logic [KIND_W-1:0]     s_axis_tuser,   // [1:0] kind
  // result items
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata    // [5:0] led_pins
);

  // LED state
  level_t                 led_level   [LED_NUM];
  level_t                 pulse_peak  [LED_NUM];
  logic [LED_NUM-1:0]     pulse_mode;
  logic [LED_NUM-1:0]     ramp_down;
  logic [SLICE_W-1:0]     slice_index;
  logic [HOLD_W-1:0]      hold_count;
  logic [PERIOD_W-1:0]    pass_count;
  logic [LED_NUM-1:0]     pin_state;
  logic [PERIOD_W-1:0]    update_period;

  level_t                 led_level_next  [LED_NUM];
  level_t                 pulse_peak_next [LED_NUM];
  logic [LED_NUM-1:0]     pulse_mode_next;
  logic [LED_NUM-1:0]     ramp_down_next;
  logic [SLICE_W-1:0]     slice_index_next;
  logic [HOLD_W-1:0]      hold_count_next;
  logic [PERIOD_W-1:0]    pass_count_next;
  logic [LED_NUM-1:0]     pin_state_next;

  // output queue
  logic                   out_valid;
  logic [PINS_W-1:0]      out_pins;
  logic                   skid_valid;
  logic [PINS_W-1:0]      skid_pins;

  kind_t                  kind;
  logic [LED_NUM-1:0]     sel;
  level_t                 value;
  level_t                 slice_weight;
  logic                   push;
  logic                   pop;

  assign kind  = kind_t'(s_axis_tuser);
  assign sel   = LED_NUM'(s_axis_tdata[MASK_W-1:0]);
  assign value = LEVEL_BITS'(s_axis_tdata[MASK_W +: VALUE_W]);

  assign s_axis_tready = !skid_valid;
  assign push = s_axis_tvalid && s_axis_tready;
  assign pop  = out_valid && m_axis_tready;

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = OUT_DATA_W'(out_pins);

  assign slice_weight = level_t'(1) << slice_index;

  // next state for the item on the input
  always_comb begin
    led_level_next   = led_level;
    pulse_peak_next  = pulse_peak;
    pulse_mode_next  = pulse_mode;
    ramp_down_next   = ramp_down;
    slice_index_next = slice_index;
    hold_count_next  = hold_count;
    pass_count_next  = pass_count;
    pin_state_next   = pin_state;
    case (kind)
      KIND_MOD_TICK: begin
        // show the current bit plane, then hold it for its weight in ticks
        if (hold_count == '0) begin
          for (int i = 0; i < LED_NUM; i++) begin
            pin_state_next[i] = led_level[i][slice_index];
          end
          hold_count_next = HOLD_W'(slice_weight - level_t'(1));
          if (slice_index == SLICE_W'(LEVEL_BITS - 1)) begin
            slice_index_next = '0;
          end else begin
            slice_index_next = slice_index + SLICE_W'(1);
          end
        end else begin
          hold_count_next = hold_count - HOLD_W'(1);
        end
      end
      KIND_PASS_TICK: begin
        if (pass_count < update_period) begin
          pass_count_next = pass_count + PERIOD_W'(1);
        end else begin
          // step every pulsing LED one notch along its ramp, or turn it at the peak or at zero
          pass_count_next = '0;
          for (int i = 0; i < LED_NUM; i++) begin
            if (pulse_mode[i]) begin
              if (!ramp_down[i]) begin
                if (led_level[i] < pulse_peak[i]) begin
                  led_level_next[i] = led_level[i] + level_t'(1);
                end else begin
                  ramp_down_next[i] = 1'b1;
                end
              end else begin
                if (led_level[i] != '0) begin
                  led_level_next[i] = led_level[i] - level_t'(1);
                end else begin
                  ramp_down_next[i] = 1'b0;
                end
              end
            end
          end
        end
      end
      KIND_SET_SOLID: begin
        pin_state_next = '0;
        for (int i = 0; i < LED_NUM; i++) begin
          if (sel[i]) begin
            pulse_mode_next[i] = 1'b0;
            led_level_next[i]  = value;
          end
        end
      end
      KIND_START_PULSE: begin
        pin_state_next = '0;
        for (int i = 0; i < LED_NUM; i++) begin
          if (sel[i]) begin
            pulse_peak_next[i] = value;
            pulse_mode_next[i] = 1'b1;
            ramp_down_next[i]  = 1'b0;
            led_level_next[i]  = '0;
          end
        end
      end
      default: begin
        pin_state_next = pin_state;
      end
    endcase
  end

  // state registers: advance only on an accepted item; update_period loads on cfg_wr_en
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LED_NUM; i++) begin
        led_level[i]  <= '0;
        pulse_peak[i] <= '0;
      end
      pulse_mode    <= '0;
      ramp_down     <= '0;
      slice_index   <= '0;
      hold_count    <= '0;
      pass_count    <= '0;
      pin_state     <= '0;
      update_period <= PERIOD_RESET;
    end else begin
      if (cfg_wr_en) begin
        update_period <= cfg_wr_data;
      end
      if (push) begin
        led_level   <= led_level_next;
        pulse_peak  <= pulse_peak_next;
        pulse_mode  <= pulse_mode_next;
        ramp_down   <= ramp_down_next;
        slice_index <= slice_index_next;
        hold_count  <= hold_count_next;
        pass_count  <= pass_count_next;
        pin_state   <= pin_state_next;
      end
    end
  end

  // output queue: the skid entry catches a result while the output stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_pins <= skid_pins;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        out_pins <= PINS_W'(pin_state_next);
      end else begin
        skid_pins <= PINS_W'(pin_state_next);
      end
    end
  end

endmodule

### verif/bit_angle_led_driver_with_pulse_test.sv
// Self-checking testbench for the bit angle LED driver with pulse ramps.
`timescale 1ns / 100ps

module bit_angle_led_driver_with_pulse_test;
  import baled_pkg::*;

  // Clock, reset and block ports; every input starts at a known value.
  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_wr_en = 1'b0;
  logic [PERIOD_W-1:0]   cfg_wr_data = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // [5:0] led_mask, [13:6] level_value
  logic [KIND_W-1:0]     s_axis_tuser = '0;   // [1:0] kind
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;        // [5:0] led_pins

  bit_angle_led_driver_with_pulse dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the driver state, advanced once per accepted item.
  level_t                led_lvl [LED_NUM];
  bit                    pulsing [LED_NUM];
  bit                    falling [LED_NUM];
  level_t                peak    [LED_NUM];
  logic [SLICE_W-1:0]    slice;
  logic [HOLD_W-1:0]     hold_cnt;
  logic [PERIOD_W-1:0]   pass_cnt;
  logic [PINS_W-1:0]     pins_now;
  logic [PERIOD_W-1:0]   period;

  // Pin states still owed by the block, oldest first.
  logic [PINS_W-1:0]     expected_pins_q [$];

  int err_count   = 0;
  int burst_left  = 0;   // items left in the current sender burst
  int gap_max     = 0;   // longest sender gap; zero keeps tvalid up
  int stall_pct   = 0;   // chance in percent that the receiver stalls a cycle
  int holdoff_req = 0;   // long receiver hold-off asked by a test
  int holdoff_left = 0;

  function automatic void reset_shadow();
    for (int i = 0; i < LED_NUM; i++) begin
      led_lvl[i] = '0;
      pulsing[i] = 1'b0;
      falling[i] = 1'b0;
      peak[i]    = '0;
    end
    slice    = '0;
    hold_cnt = '0;
    pass_cnt = '0;
    pins_now = '0;
    period   = PERIOD_RESET;
  endfunction

  // Advance the shadow state by one item and return the pins it leaves.
  function automatic logic [PINS_W-1:0] predict_pins(kind_t k, logic [MASK_W-1:0] m,
                                                      level_t v);
    logic [PINS_W-1:0] p;
    p = '0;
    case (k)
      KIND_MOD_TICK: begin
        // Drive bit 'slice' of every level, then hold it 2^slice ticks in all.
        if (hold_cnt == 0) begin
          for (int i = 0; i < LED_NUM; i++) p[i] = led_lvl[i][slice];
          pins_now = p;
          hold_cnt = HOLD_W'((1 << slice) - 1);
          slice    = (slice == LEVEL_BITS - 1) ? '0 : slice + 1'b1;
        end else begin
          hold_cnt = hold_cnt - 1'b1;
        end
      end
      KIND_PASS_TICK: begin
        if (pass_cnt < period) begin
          pass_cnt = pass_cnt + 1'b1;
        end else begin
          // Ramp step: up to the peak, turn, down to zero, turn.
          pass_cnt = '0;
          for (int i = 0; i < LED_NUM; i++) begin
            if (pulsing[i]) begin
              if (!falling[i]) begin
                if (led_lvl[i] < peak[i]) led_lvl[i]++;
                else falling[i] = 1'b1;
              end else begin
                if (led_lvl[i] > 0) led_lvl[i]--;
                else falling[i] = 1'b0;
              end
            end
          end
        end
      end
      default: begin
        // Commands drop all pins; direction survives a solid level.
        pins_now = '0;
        for (int i = 0; i < LED_NUM; i++) begin
          if (m[i]) begin
            if (k == KIND_SET_SOLID) begin
              pulsing[i] = 1'b0;
              led_lvl[i] = v;
            end else begin
              peak[i]    = v;
              pulsing[i] = 1'b1;
              falling[i] = 1'b0;
              led_lvl[i] = '0;
            end
          end
        end
      end
    endcase
    return pins_now;
  endfunction

  // Offer one item and hold it until accepted. Enter and leave on a rising edge.
  task automatic send_item(kind_t k, logic [MASK_W-1:0] m, level_t v);
    if (burst_left == 0) begin
      if (gap_max != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, gap_max)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 50);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_DATA_W - MASK_W - VALUE_W){1'b0}}, v, m};
    s_axis_tuser  <= k;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    burst_left--;
    expected_pins_q.push_back(predict_pins(k, m, v));
  endtask

  // Drop tvalid, wait for every owed result, then let the block sit quiet.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (expected_pins_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_period(logic [PERIOD_W-1:0] value);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    period = value;
  endtask

  // Receiver: check each accepted result, then pick next cycle's tready.
  always @(posedge clk) begin : result_check
    logic [PINS_W-1:0] want;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_pins_q.size() == 0) begin
          err_count++;
          if (err_count <= 10)
            $display("unexpected result led_pins %b at %0t",
                     m_axis_tdata[PINS_W-1:0], $time);
        end else begin
          want = expected_pins_q.pop_front();
          if (m_axis_tdata[PINS_W-1:0] !== want) begin
            err_count++;
            if (err_count <= 10)
              $display("mismatch led_pins expected %b got %b at %0t",
                       want, m_axis_tdata[PINS_W-1:0], $time);
          end
        end
      end
      if (holdoff_req != 0) begin
        holdoff_left = holdoff_req;
        holdoff_req  = 0;
      end
      if (holdoff_left != 0) begin
        holdoff_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= (stall_pct == 0) || ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // Solid levels, pin clearing and an empty mask under the reset period.
  task automatic test_directed_commands();
    gap_max   = 0;
    stall_pct = 0;
    send_item(KIND_SET_SOLID, 6'h3F, 8'hFF);
    repeat (3) send_item(KIND_MOD_TICK, 6'h00, 8'h00);
    send_item(KIND_SET_SOLID, 6'h15, 8'h00);   // drops pins, sequence carries on
    repeat (3) send_item(KIND_MOD_TICK, 6'h3F, 8'hFF);
    send_item(KIND_SET_SOLID, 6'h00, 8'hA5);   // no LED selected, pins still low
    send_item(KIND_START_PULSE, 6'h00, 8'h5A);
    send_item(KIND_SET_SOLID, 6'h2A, 8'h80);
    repeat (4) send_item(KIND_MOD_TICK, 6'h00, 8'h00);
    send_item(KIND_PASS_TICK, 6'h3F, 8'hFF);   // period 255, no ramp step yet
  endtask

  // Ramp up, turn at the peak, down, turn at zero; a zero peak turns at once.
  task automatic test_pulse_ramp();
    write_period('0);
    send_item(KIND_START_PULSE, 6'h01, 8'd2);
    send_item(KIND_START_PULSE, 6'h02, 8'hFF);
    send_item(KIND_START_PULSE, 6'h04, 8'd0);
    repeat (6) begin
      send_item(KIND_PASS_TICK, 6'h00, 8'h00);
      send_item(KIND_MOD_TICK, 6'h00, 8'h00);
    end
    send_item(KIND_SET_SOLID, 6'h01, 8'h0F);   // leave pulse mode, keep direction
    send_item(KIND_PASS_TICK, 6'h00, 8'h00);
    send_item(KIND_MOD_TICK, 6'h00, 8'h00);
  endtask

  // Mostly ticks with occasional commands; small peaks reach both turns often.
  task automatic test_random_traffic(logic [PERIOD_W-1:0] per, int count, int gaps,
                                     int stalls);
    kind_t             k;
    logic [MASK_W-1:0] m;
    level_t            v;
    int                r;
    write_period(per);
    gap_max   = gaps;
    stall_pct = stalls;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 50)      k = KIND_MOD_TICK;
      else if (r < 82) k = KIND_PASS_TICK;
      else if (r < 91) k = KIND_SET_SOLID;
      else             k = KIND_START_PULSE;
      m = MASK_W'($urandom);
      v = level_t'($urandom);
      if (k == KIND_START_PULSE && $urandom_range(0, 3) != 0)
        v = level_t'($urandom_range(0, 6));
      send_item(k, m, v);
    end
  endtask

  // Hold off the receiver for a long stretch while the sender keeps offering items.
  task automatic test_output_backpressure();
    gap_max   = 0;
    stall_pct = 0;
    holdoff_req = 300;
    repeat (100)
      send_item(kind_t'($urandom_range(0, 3)), MASK_W'($urandom), level_t'($urandom));
    stall_pct = 50;
    repeat (60)
      send_item(kind_t'($urandom_range(0, 3)), MASK_W'($urandom), level_t'($urandom));
  endtask

  initial begin
    reset_shadow();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_directed_commands();
    test_pulse_ramp();
    test_random_traffic(16'd0, 500, 6, 30);
    test_random_traffic(16'd1, 350, 0, 0);
    test_random_traffic(16'hFFFF, 200, 4, 60);
    test_random_traffic(16'($urandom_range(2, 12)), 350, 8, 20);
    test_output_backpressure();
    test_random_traffic(PERIOD_RESET, 100, 3, 40);
    wait_idle();
    repeat (16) @(posedge clk);
    if (err_count == 0)
      $display("bit_angle_led_driver_with_pulse verification clean");
    else
      $display("bit_angle_led_driver_with_pulse verification failed");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("bit_angle_led_driver_with_pulse verification failed");
    $finish;
  end

endmodule
